@@ src/bice_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bice_pkg
// Shared types and constants of the binary contour extraction block.
// ----------------------------------------------------------------------------
package bice_pkg;

  // kind of input word, carried on tuser
  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  localparam int unsigned FW_WIDTH       = 11;
  localparam int unsigned FH_WIDTH       = 13;
  localparam int unsigned BLUE_WIDTH     = 8;
  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam int unsigned APB_DATA_WIDTH = 32;

  localparam logic [FW_WIDTH-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_WIDTH-1:0] FRAME_HEIGHT_RST = 13'd480;

  // row store request from the control side
  typedef struct packed {
    logic load;       // pixel word accepted
    logic now_zero;   // incoming pixel is zero
  } rs_req_t;

  // prefetched flags for the next pixel column
  typedef struct packed {
    logic center;     // zero flag one row back, same column
    logic up;         // zero flag two rows back, same column
    logic right;      // zero flag one row back, next column
  } rs_rsp_t;

endpackage

@@ src/bice_row_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bice_row_store
// Two one-bit row memories of zero flags. On each pixel word the entry of
// the current column is rewritten and the flags of the next column are
// read ahead, so they are ready in their read registers for the next word.
// ----------------------------------------------------------------------------
module bice_row_store #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  bice_pkg::rs_req_t             req_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  nxt_col_i,
  output bice_pkg::rs_rsp_t             rsp_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic prev_mem [MAX_WIDTH];
  logic curr_mem [MAX_WIDTH];

  logic          center_q;
  logic          up_q;
  logic          right_q;
  logic [CW:0]   right_sum;
  logic [CW-1:0] right_col;

  // address of the right neighbour of the next column, kept in range
  assign right_sum = {1'b0, nxt_col_i} + (CW+1)'(1);
  assign right_col = (right_sum >= (CW+1)'(MAX_WIDTH)) ? '0 : right_sum[CW-1:0];

  // row two back: takes the flag that moves down from the row one back
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prev_mem[wr_col_i] <= center_q;
      up_q               <= prev_mem[nxt_col_i];
    end
  end

  // row one back: takes the incoming flag, read ahead at two columns
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      curr_mem[wr_col_i] <= req_i.now_zero;
      center_q           <= curr_mem[nxt_col_i];
      right_q            <= curr_mem[right_col];
    end
  end

  assign rsp_o.center = center_q;
  assign rsp_o.up     = up_q;
  assign rsp_o.right  = right_q;

endmodule

@@ src/binary_image_contour_extract_top.sv @@
`timescale 1ns / 1ps
// Output: a result is registered and shown on the master side in the cycle after its word is accepted.
// Throughput: one word per cycle while the master side takes results; the row memories take one write and read ahead
// the next column's flags on every pixel word, so no word waits on a memory read.
// Reset: counters, left flag and output valid cleared, frame_width 640,
// frame_height 480; row memory contents are not initialized.
// ----------------------------------------------------------------------------
// binary_image_contour_extract_top
// 4-neighbour contour extraction over a raster pixel stream. Each pixel word's result is
// the black or white verdict of the pixel one row above the incoming one.
// ----------------------------------------------------------------------------
module binary_image_contour_extract_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // stream in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [bice_pkg::BLUE_WIDTH-1:0]       s_axis_tdata,  // [7:0] pixel_blue
  input  logic                                  s_axis_tuser,  // [0] mode
  // stream out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [7:0]                            m_axis_tdata,  // [0] edge_pixel, [7:1] zero
  output logic                                  m_axis_tlast,  // end_of_frame
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bice_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [bice_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [bice_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = CW + 1;
  localparam int unsigned WCMP = (WW > bice_pkg::FW_WIDTH) ? WW : bice_pkg::FW_WIDTH;
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned HW   = RW + 1;
  localparam int unsigned HCMP = (HW > bice_pkg::FH_WIDTH) ? HW : bice_pkg::FH_WIDTH;

  logic [bice_pkg::FW_WIDTH-1:0] frame_width_q;
  logic [bice_pkg::FH_WIDTH-1:0] frame_height_q;
  logic [CW-1:0]                 col_q, col_d;
  logic [RW-1:0]                 row_q, row_d;
  logic [CW-1:0]                 flush_q, flush_d;
  logic                          left_q, left_d;
  logic                          out_valid_q, out_valid_d;
  logic                          edge_q, edge_d;
  logic                          eof_q, eof_d;

  logic [WCMP-1:0]   fw_ext;
  logic [HCMP-1:0]   fh_ext;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic              cfg_wr;
  bice_pkg::reg_idx_e cfg_idx;
  logic              in_acc;
  logic              is_flush;
  logic              pix_acc;
  logic              now_zero;
  logic              col_last;
  logic              row_last;
  logic              flush_last;
  logic              inner;
  logic              pix_edge;
  bice_pkg::rs_req_t rs_req;
  bice_pkg::rs_rsp_t rs_rsp;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = bice_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bice_pkg::FRAME_WIDTH_RST;
      frame_height_q <= bice_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bice_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[bice_pkg::FW_WIDTH-1:0];
        bice_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[bice_pkg::FH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      bice_pkg::REG_FRAME_WIDTH:
        prdata = bice_pkg::APB_DATA_WIDTH'(frame_width_q);
      bice_pkg::REG_FRAME_HEIGHT:
        prdata = bice_pkg::APB_DATA_WIDTH'(frame_height_q);
      default: prdata = '0;
    endcase
  end

  // clamp frame size to the supported range
  assign fw_ext = WCMP'(frame_width_q);
  assign fh_ext = HCMP'(frame_height_q);

  always_comb begin
    if (fw_ext < WCMP'(3)) begin
      w_eff = WW'(3);
    end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext[WW-1:0];
    end
    if (fh_ext < HCMP'(3)) begin
      h_eff = HW'(3);
    end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext[HW-1:0];
    end
  end

  // input handshake: output register frees up as it is drained
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign is_flush      = (bice_pkg::mode_e'(s_axis_tuser) == bice_pkg::MODE_FLUSH);
  assign pix_acc       = in_acc & ~is_flush;
  assign now_zero      = (s_axis_tdata == '0);

  // position tests
  assign col_last   = (({1'b0, col_q} + WW'(1)) >= w_eff);
  assign row_last   = (({1'b0, row_q} + HW'(1)) >= h_eff);
  assign flush_last = (({1'b0, flush_q} + WW'(1)) >= w_eff);
  assign inner      = (col_q != '0) && ((({1'b0, col_q}) + WW'(2)) <= w_eff)
                   && (row_q >= RW'(2)) && ((({1'b0, row_q}) + HW'(1)) <= h_eff);

  // contour test for the pixel one row back
  assign pix_edge = inner & rs_rsp.center
                  & (~left_q | ~rs_rsp.right | ~rs_rsp.up | ~now_zero);

  // counters and left flag
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    left_d  = left_q;
    if (in_acc && is_flush) begin
      flush_d = flush_last ? '0 : flush_q + CW'(1);
    end
    if (pix_acc) begin
      left_d = rs_rsp.center;
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready;
    edge_d      = edge_q;
    eof_d       = eof_q;
    if (in_acc && is_flush) begin
      out_valid_d = 1'b1;
      edge_d      = 1'b0;
      eof_d       = flush_last;
    end else if (pix_acc && (row_q != '0)) begin
      out_valid_d = 1'b1;
      edge_d      = pix_edge;
      eof_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      flush_q     <= '0;
      left_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      flush_q     <= flush_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    eof_q  <= eof_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, edge_q};
  assign m_axis_tlast  = eof_q;

  // row flag memories
  assign rs_req.load     = pix_acc;
  assign rs_req.now_zero = now_zero;

  bice_row_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i     (clk_i),
    .req_i     (rs_req),
    .wr_col_i  (col_q),
    .nxt_col_i (col_d),
    .rsp_o     (rs_rsp)
  );

endmodule
